[rtl/vgdr_pkg.sv]
// Package: word types, register indexes, reset values and helpers for the recorder.
`timescale 1ns / 1ps
`default_nettype none
package vgdr_pkg;

   localparam int CHUNK_MAX = 64;
   localparam int AW = $clog2(CHUNK_MAX);
   localparam int NW = AW + 1;

   localparam logic [18:0] MAX_REC_RST = 19'd160000;
   localparam logic [7:0]  GAIN_RST    = 8'd1;
   localparam logic [12:0] VAD_THR_RST = 13'd500;
   localparam logic [17:0] MIN_REC_RST = 18'd4800;
   localparam logic [17:0] SIL_STP_RST = 18'd3200;
   localparam logic [19:0] SILENCE_SAT = 20'hFFFFF;

   typedef enum logic [2:0] {
      CSR_MAX_REC = 3'd0,
      CSR_GAIN    = 3'd1,
      CSR_VAD_THR = 3'd2,
      CSR_VAD_EN  = 3'd3,
      CSR_MIN_REC = 3'd4,
      CSR_SIL_STP = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEV_ADDR,
      ST_DEV_MUL,
      ST_DEV_ACC,
      ST_THR_A,
      ST_THR_B,
      ST_DECIDE,
      ST_EM_ADDR,
      ST_EM_MUL,
      ST_EM_CEN,
      ST_EM_GAIN,
      ST_EM_DIV,
      ST_EM_OUT
   } state_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] raw_sample;
      logic               chunk_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm;
      logic               run_last;
      logic               speech_seen;
      logic               recording_done;
      logic               stopped_by_vad;
      logic [18:0]        recorded_count;
   } rsp_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
      logic signed [15:0] r;
      if (x > 32'sd32767) r = 16'sh7FFF;
      else if (x < -32'sd32768) r = 16'sh8000;
      else r = x[15:0];
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/vgdr_store.sv]
// Chunk sample memory, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module vgdr_store (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [vgdr_pkg::AW-1:0]  waddr,
   input  wire logic signed [15:0]       wdata,
   input  wire logic [vgdr_pkg::AW-1:0]  raddr,
   output logic signed [15:0]            rdata_ff
);
   logic signed [15:0] mem [vgdr_pkg::CHUNK_MAX];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

[rtl/vgdr_div.sv]
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module vgdr_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [31:0]       dividend,
   input  wire logic [vgdr_pkg::NW-1:0]  divisor,
   output logic                          done,
   output logic signed [31:0]            quotient
);
   logic                    busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [31:0]             q_ff, q_in;
   logic [vgdr_pkg::NW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [vgdr_pkg::NW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, q_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[31];
         q_in    = dividend[31] ? 32'(-dividend) : 32'(dividend);
         rem_in  = '0;
         cnt_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = vgdr_pkg::NW'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[vgdr_pkg::NW-1:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule
`default_nettype wire

[rtl/vad_gated_dc_removed_recorder.sv]
// Top level: chunk buffering, deviation and speech decision sequencer, centred output.
// Sequence: after the chunk end word of a chunk, the deviation pass and speech decision
// run, then each result word is set up, divided in the divider and output, and is held
// while rsp_stall is high.
// Input words are accepted while the block is idle; it is busy during analysis/emit.
// Reset (synchronous, active high) restores register defaults and clears the recording.
`timescale 1ns / 1ps
`default_nettype none
module vad_gated_dc_removed_recorder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vgdr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vgdr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);
   localparam int AW = vgdr_pkg::AW;
   localparam int NW = vgdr_pkg::NW;

   vgdr_pkg::state_type state_ff, state_in;

   logic [18:0] max_rec_ff;
   logic [7:0]  gain_ff;
   logic [12:0] vad_thr_ff;
   logic        vad_en_ff;
   logic [17:0] min_rec_ff, sil_stp_ff;

   logic [NW-1:0]      fill_ff, fill_in;
   logic signed [22:0] total_ff, total_in;
   logic [18:0]        written_ff, written_in;
   logic               speech_ff, speech_in, done_ff, done_in, vstop_ff, vstop_in;
   logic [19:0]        sil_ff, sil_in;
   logic [AW-1:0]      k_ff, k_in;
   logic signed [23:0] prod_ff, prod_in;
   logic signed [24:0] c_ff, c_in, cw;
   logic [29:0]        dev_ff, dev_in;
   logic [12:0]        nn_ff, nn_in;
   logic [25:0]        thr_ff, thr_in;
   logic [18:0]        cnt_ff, cnt_in;
   logic               rv_ff, rv_in;
   vgdr_pkg::rsp_type  rsp_ff, rsp_in;

   logic               acc, we, div_start, div_done, last_k;
   logic signed [15:0] v, rdata;
   logic [AW-1:0]      raddr;
   logic signed [32:0] gp;
   logic signed [31:0] quo;
   logic [19:0]        after, sil_sum;

   vgdr_store u_store (
      .clock(clock), .we(we), .waddr(fill_ff[AW-1:0]), .wdata(v),
      .raddr(raddr), .rdata_ff(rdata)
   );

   vgdr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(gp[31:0]),
      .divisor(fill_ff), .done(div_done), .quotient(quo)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != vgdr_pkg::ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign acc       = req_valid && !req_stall;
   assign v         = req_data.raw_sample[31:16];
   assign raddr     = k_ff;
   assign last_k    = ({1'b0, k_ff} + NW'(1)) == fill_ff;
   assign cw        = 25'(prod_ff) - 25'(total_ff);
   assign gp        = $signed({1'b0, gain_ff}) * c_ff;
   assign after     = 20'(written_ff) + 20'(fill_ff);
   assign sil_sum   = sil_ff + 20'(fill_ff);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      total_in   = total_ff;
      written_in = written_ff;
      speech_in  = speech_ff;
      done_in    = done_ff;
      vstop_in   = vstop_ff;
      sil_in     = sil_ff;
      k_in       = k_ff;
      prod_in    = prod_ff;
      c_in       = c_ff;
      dev_in     = dev_ff;
      nn_in      = nn_ff;
      thr_in     = thr_ff;
      cnt_in     = cnt_ff;
      rv_in      = rv_ff;
      rsp_in     = rsp_ff;
      we         = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         vgdr_pkg::ST_IDLE: begin
            if (acc) begin
               if (req_data.kind) begin
                  fill_in    = '0;
                  total_in   = '0;
                  written_in = '0;
                  speech_in  = 1'b0;
                  sil_in     = '0;
                  done_in    = 1'b0;
                  vstop_in   = 1'b0;
               end else if (!done_ff) begin
                  if (fill_ff < NW'(vgdr_pkg::CHUNK_MAX) &&
                      after < 20'(max_rec_ff)) begin
                     we       = 1'b1;
                     fill_in  = fill_ff + NW'(1);
                     total_in = total_ff + 23'(v);
                  end
                  if (req_data.chunk_end && fill_in != '0) begin
                     k_in     = '0;
                     dev_in   = '0;
                     state_in = vgdr_pkg::ST_DEV_ADDR;
                  end
               end
            end
         end
         vgdr_pkg::ST_DEV_ADDR: state_in = vgdr_pkg::ST_DEV_MUL;
         vgdr_pkg::ST_DEV_MUL: begin
            prod_in  = 24'(fill_ff) * 24'(rdata);
            state_in = vgdr_pkg::ST_DEV_ACC;
         end
         vgdr_pkg::ST_DEV_ACC: begin
            dev_in = dev_ff + (cw[24] ? 30'(-cw) : 30'(cw));
            if (last_k) begin
               state_in = vgdr_pkg::ST_THR_A;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = vgdr_pkg::ST_DEV_ADDR;
            end
         end
         vgdr_pkg::ST_THR_A: begin
            nn_in    = 13'(fill_ff) * 13'(fill_ff);
            state_in = vgdr_pkg::ST_THR_B;
         end
         vgdr_pkg::ST_THR_B: begin
            thr_in   = 26'(nn_ff) * 26'(vad_thr_ff);
            state_in = vgdr_pkg::ST_DECIDE;
         end
         vgdr_pkg::ST_DECIDE: begin
            if (30'(thr_ff) <= dev_ff) begin
               speech_in = 1'b1;
               sil_in    = '0;
            end else if (speech_ff) begin
               sil_in = (sil_sum < sil_ff) ? vgdr_pkg::SILENCE_SAT : sil_sum;
            end
            if (vad_en_ff && speech_in && after >= 20'(min_rec_ff) &&
                sil_in >= 20'(sil_stp_ff)) begin
               done_in  = 1'b1;
               vstop_in = 1'b1;
            end
            if (after >= 20'(max_rec_ff)) done_in = 1'b1;
            cnt_in     = written_ff;
            written_in = after[18:0];
            k_in       = '0;
            state_in   = vgdr_pkg::ST_EM_ADDR;
         end
         vgdr_pkg::ST_EM_ADDR: state_in = vgdr_pkg::ST_EM_MUL;
         vgdr_pkg::ST_EM_MUL: begin
            prod_in  = 24'(fill_ff) * 24'(rdata);
            state_in = vgdr_pkg::ST_EM_CEN;
         end
         vgdr_pkg::ST_EM_CEN: begin
            c_in     = cw;
            state_in = vgdr_pkg::ST_EM_GAIN;
         end
         vgdr_pkg::ST_EM_GAIN: begin
            div_start = 1'b1;
            state_in  = vgdr_pkg::ST_EM_DIV;
         end
         vgdr_pkg::ST_EM_DIV: begin
            if (div_done) begin
               cnt_in                = cnt_ff + 19'd1;
               rsp_in.pcm            = vgdr_pkg::sat16(quo);
               rsp_in.run_last       = last_k;
               rsp_in.speech_seen    = speech_ff;
               rsp_in.recording_done = done_ff;
               rsp_in.stopped_by_vad = vstop_ff;
               rsp_in.recorded_count = cnt_ff + 19'd1;
               rv_in                 = 1'b1;
               state_in              = vgdr_pkg::ST_EM_OUT;
            end
         end
         vgdr_pkg::ST_EM_OUT: begin
            if (!rsp_stall) begin
               rv_in = 1'b0;
               if (last_k) begin
                  fill_in  = '0;
                  total_in = '0;
                  state_in = vgdr_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = vgdr_pkg::ST_EM_ADDR;
               end
            end
         end
         default: state_in = vgdr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vgdr_pkg::ST_IDLE;
         fill_ff    <= '0;
         total_ff   <= '0;
         written_ff <= '0;
         speech_ff  <= 1'b0;
         done_ff    <= 1'b0;
         vstop_ff   <= 1'b0;
         sil_ff     <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         total_ff   <= total_in;
         written_ff <= written_in;
         speech_ff  <= speech_in;
         done_ff    <= done_in;
         vstop_ff   <= vstop_in;
         sil_ff     <= sil_in;
         rv_ff      <= rv_in;
      end
      k_ff    <= k_in;
      prod_ff <= prod_in;
      c_ff    <= c_in;
      dev_ff  <= dev_in;
      nn_ff   <= nn_in;
      thr_ff  <= thr_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rec_ff <= vgdr_pkg::MAX_REC_RST;
         gain_ff    <= vgdr_pkg::GAIN_RST;
         vad_thr_ff <= vgdr_pkg::VAD_THR_RST;
         vad_en_ff  <= 1'b0;
         min_rec_ff <= vgdr_pkg::MIN_REC_RST;
         sil_stp_ff <= vgdr_pkg::SIL_STP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vgdr_pkg::CSR_MAX_REC: max_rec_ff <= csr_wdata[18:0];
            vgdr_pkg::CSR_GAIN:    gain_ff    <= csr_wdata[7:0];
            vgdr_pkg::CSR_VAD_THR: vad_thr_ff <= csr_wdata[12:0];
            vgdr_pkg::CSR_VAD_EN:  vad_en_ff  <= csr_wdata[0];
            vgdr_pkg::CSR_MIN_REC: min_rec_ff <= csr_wdata[17:0];
            vgdr_pkg::CSR_SIL_STP: sil_stp_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/vgdr_checker.sv]
// Port-level checks for the recorder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vgdr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire vgdr_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result word is pending");

   a_vad_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stopped_by_vad |-> rsp_data.recording_done)
      else $error("silence stop without done");

   a_vad_speech: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stopped_by_vad |-> rsp_data.speech_seen)
      else $error("silence stop without speech");
endmodule

bind vad_gated_dc_removed_recorder vgdr_checker u_vgdr_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
`default_nettype wire
